// ----- rtl/core/ssf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared sizes, command/status types and arithmetic helpers for the subpixel
// splat frame buffer.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int COLS   = 16;
  localparam int ROWS   = 16;
  localparam int NPIX   = COLS * ROWS;
  localparam int ADDR_W = $clog2(NPIX);

  localparam int POS_W  = 12;
  localparam int FRAC_W = 8;
  localparam int CRD_W  = 4;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  // Neighbor coordinates, wide enough to compare against COLS and ROWS
  localparam int NB_W   = 10;

  typedef enum logic {OP_PLOT = 1'b0, OP_READ = 1'b1} op_e;

  typedef struct packed {
    logic       capture;
    logic       weigh;
    logic       rd_en;
    logic [1:0] nb;
    logic       wr_en;
    logic       rsp;
  } ssf_cmd_t;

  typedef struct packed {
    logic is_read;
    logic nb_ok;
    logic out_free;
  } ssf_sts_t;

  function automatic logic [CH_W-1:0] frac_scale(input logic [FRAC_W-1:0] f);
    logic [15:0] p;
    p = {f, 8'h00} - {8'h00, f};
    return p[15:8];
  endfunction

  function automatic logic [CH_W-1:0] corner_weight(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b);
    logic [15:0] p;
    p = (16'(a) * 16'(b)) + 16'(a) + 16'(b);
    return p[15:8];
  endfunction

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] base,
                                              input logic [CH_W-1:0] add);
    logic [CH_W:0] s;
    s = {1'b0, base} + {1'b0, add};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

endpackage

// ----- rtl/core/subpixel_splat_framebuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpixel_splat_framebuffer
// RGB frame store with Wu-weighted subpixel plotting and single-pixel readback.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid_i/in_ready_o  | op, x_pos, y_pos, red/green/blue_in,
//          |                        | read_col, read_row
//  out     | out_valid_o/out_ready_i| pix_red, pix_green, pix_blue
//
// One request at a time. A plot holds the input from acceptance to the next
// acceptance through capture, weights, then a read and a write per neighbor
// in the frame store; a neighbor off the edge is skipped with no read or write.
// A read passes capture, weights and a lookup, and waits while the output register stays full.
// Reset clears the per-pixel valid bits at once, so the store reads black.
// A plot never waits on the output side.
// ----------------------------------------------------------------------------
module subpixel_splat_framebuffer
  import ssf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [POS_W-1:0] x_pos_i,
  input  logic [POS_W-1:0] y_pos_i,
  input  logic [CH_W-1:0]  red_in_i,
  input  logic [CH_W-1:0]  green_in_i,
  input  logic [CH_W-1:0]  blue_in_i,
  input  logic [CRD_W-1:0] read_col_i,
  input  logic [CRD_W-1:0] read_row_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CH_W-1:0]  pix_red_o,
  output logic [CH_W-1:0]  pix_green_o,
  output logic [CH_W-1:0]  pix_blue_o
);

  ssf_cmd_t cmd;
  ssf_sts_t sts;

  ssf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ssf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (op_i),
    .x_pos_i    (x_pos_i),
    .y_pos_i    (y_pos_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .read_col_i (read_col_i),
    .read_row_i (read_row_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pix_red_o  (pix_red_o),
    .pix_green_o(pix_green_o),
    .pix_blue_o (pix_blue_o)
  );

endmodule

// ----- rtl/core/ssf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ssf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ssf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_ctrl
// Sequencer: accepts a request, steps the datapath through weight setup and
// one read-modify-write per in-range neighbor, or a single lookup for a read.
// ----------------------------------------------------------------------------
module ssf_ctrl
  import ssf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ssf_sts_t sts_i,
  output ssf_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WEIGH = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_RSP   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] nb_q, nb_d;

  always_comb begin
    state_d    = state_q;
    nb_d       = nb_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.nb   = nb_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          nb_d          = 2'd0;
          state_d       = S_WEIGH;
        end
      end
      S_WEIGH: begin
        cmd_o.weigh = 1'b1;
        state_d     = S_RD;
      end
      S_RD: begin
        if (sts_i.is_read) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_RSP;
        end else if (sts_i.nb_ok) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_WR;
        end else if (nb_q == 2'd3) begin
          state_d = S_IDLE;
        end else begin
          nb_d = nb_q + 2'd1;
        end
      end
      S_WR: begin
        cmd_o.wr_en = 1'b1;
        if (nb_q == 2'd3) begin
          state_d = S_IDLE;
        end else begin
          nb_d    = nb_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_RSP: begin
        if (sts_i.out_free) begin
          cmd_o.rsp = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nb_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      nb_q    <= nb_d;
    end
  end

endmodule

// ----- rtl/core/ssf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_dp
// Datapath: request registers, Wu weights, channel products, saturating
// update of the frame store, per-pixel valid bits and the output register.
// ----------------------------------------------------------------------------
module ssf_dp
  import ssf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssf_cmd_t         cmd_i,
  output ssf_sts_t         sts_o,
  input  logic             op_i,
  input  logic [POS_W-1:0] x_pos_i,
  input  logic [POS_W-1:0] y_pos_i,
  input  logic [CH_W-1:0]  red_in_i,
  input  logic [CH_W-1:0]  green_in_i,
  input  logic [CH_W-1:0]  blue_in_i,
  input  logic [CRD_W-1:0] read_col_i,
  input  logic [CRD_W-1:0] read_row_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CH_W-1:0]  pix_red_o,
  output logic [CH_W-1:0]  pix_green_o,
  output logic [CH_W-1:0]  pix_blue_o
);

  logic              op_q;
  logic [CRD_W-1:0]  col_q, row_q;
  logic [CH_W-1:0]   xx_q, yy_q;
  logic [CH_W-1:0]   chan_q [3];
  logic [CH_W-1:0]   w_q [4];
  logic [CH_W-1:0]   prod_q [3];
  logic [ADDR_W-1:0] addr_q;
  logic              vld_rd_q;
  logic [NPIX-1:0]   valid_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  out_q;

  logic [NB_W-1:0]   nb_col, nb_row;
  logic              in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [CH_W-1:0]   ix, iy;
  logic [CH_W-1:0]   w_sel;
  logic [PIX_W-1:0]  ram_rdata;
  logic [PIX_W-1:0]  base_pix;
  logic [PIX_W-1:0]  new_pix;

  // Read requests look up the pixel itself; plots walk the four neighbors
  assign nb_col   = NB_W'(col_q) + NB_W'(cmd_i.nb[0] & (op_q == OP_PLOT));
  assign nb_row   = NB_W'(row_q) + NB_W'(cmd_i.nb[1] & (op_q == OP_PLOT));
  assign in_range = (nb_col < NB_W'(COLS)) && (nb_row < NB_W'(ROWS));
  assign rd_addr  = ADDR_W'(int'(nb_row) * COLS + int'(nb_col));

  assign ix    = 8'd255 - xx_q;
  assign iy    = 8'd255 - yy_q;
  assign w_sel = w_q[cmd_i.nb];

  assign base_pix = ram_rdata & {PIX_W{vld_rd_q}};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      new_pix[c*CH_W +: CH_W] = sat_add(base_pix[c*CH_W +: CH_W], prod_q[c]);
    end
  end

  ssf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(NPIX)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(addr_q),
    .wdata_i(new_pix),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      col_q     <= (op_i == OP_READ) ? read_col_i : x_pos_i[POS_W-1:FRAC_W];
      row_q     <= (op_i == OP_READ) ? read_row_i : y_pos_i[POS_W-1:FRAC_W];
      xx_q      <= frac_scale(x_pos_i[FRAC_W-1:0]);
      yy_q      <= frac_scale(y_pos_i[FRAC_W-1:0]);
      chan_q[0] <= red_in_i;
      chan_q[1] <= green_in_i;
      chan_q[2] <= blue_in_i;
    end
    if (cmd_i.weigh) begin
      w_q[0] <= corner_weight(ix, iy);
      w_q[1] <= corner_weight(xx_q, iy);
      w_q[2] <= corner_weight(ix, yy_q);
      w_q[3] <= corner_weight(xx_q, yy_q);
    end
    if (cmd_i.rd_en) begin
      addr_q <= rd_addr;
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= 8'((16'(chan_q[c]) * 16'(w_sel)) >> 8);
      end
    end
    if (cmd_i.rsp) begin
      out_q <= base_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[addr_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        vld_rd_q <= in_range & valid_q[rd_addr];
      end
      if (cmd_i.rsp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_read  = (op_q == OP_READ);
  assign sts_o.nb_ok    = in_range;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pix_red_o   = out_q[0*CH_W +: CH_W];
  assign pix_green_o = out_q[1*CH_W +: CH_W];
  assign pix_blue_o  = out_q[2*CH_W +: CH_W];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the subpixel splat frame buffer against a cycle-free shadow frame.
// Plots update the shadow copy with Wu weights and clamped adds. Reads queue
// the shadow pixel, and each returned pixel is compared field by field. The
// directed requests cover the edges and saturation. The random requests then
// run through phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top
  import ssf_pkg::*;
();

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_ITEMS  = 1840;

  class splat_tracker;
    logic [CH_W-1:0] shadow_frame [NPIX][3];
    pixel_t          pending_pixels [$];
    int              mismatches;

    function new();
      foreach (shadow_frame[i, c]) shadow_frame[i][c] = '0;
      mismatches = 0;
    endfunction

    function logic [CH_W-1:0] scale_frac(logic [FRAC_W-1:0] f);
      logic [15:0] p;
      p = 16'(f) * 16'd255;
      return p[15:8];
    endfunction

    function logic [CH_W-1:0] blend_weight(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
      logic [15:0] p;
      p = 16'(a) * 16'(b) + 16'(a) + 16'(b);
      return p[15:8];
    endfunction

    function logic [CH_W-1:0] add_clamped(logic [CH_W-1:0] base, logic [CH_W-1:0] add);
      logic [CH_W:0] s;
      s = {1'b0, base} + {1'b0, add};
      return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
    endfunction

    function void note_mismatch(string field, logic [PIX_W-1:0] expv,
                                logic [PIX_W-1:0] actv);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h actual %0h", $time, field, expv, actv);
    endfunction

    function void note_request(op_e op, logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                               logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                               logic [CH_W-1:0] b, logic [CRD_W-1:0] rc,
                               logic [CRD_W-1:0] rr);
      int              col, row, xn, yn, idx;
      logic [CH_W-1:0] xx, yy, ix, iy;
      logic [CH_W-1:0] wts [4];
      logic [CH_W-1:0] rgb [3];
      logic [15:0]     prod;
      pixel_t          px;
      if (op == OP_READ) begin
        px = '0;
        if (rc < COLS && rr < ROWS) begin
          idx = int'(rr) * COLS + int'(rc);
          px.red   = shadow_frame[idx][0];
          px.green = shadow_frame[idx][1];
          px.blue  = shadow_frame[idx][2];
        end
        pending_pixels.push_back(px);
        return;
      end
      col = int'(xp[POS_W-1:FRAC_W]);
      row = int'(yp[POS_W-1:FRAC_W]);
      xx  = scale_frac(xp[FRAC_W-1:0]);
      yy  = scale_frac(yp[FRAC_W-1:0]);
      ix  = 8'd255 - xx;
      iy  = 8'd255 - yy;
      wts[0] = blend_weight(ix, iy);
      wts[1] = blend_weight(xx, iy);
      wts[2] = blend_weight(ix, yy);
      wts[3] = blend_weight(xx, yy);
      rgb[0] = r;
      rgb[1] = g;
      rgb[2] = b;
      for (int k = 0; k < 4; k++) begin
        xn = col + (k & 1);
        yn = row + (k >> 1);
        // neighbors past the right or bottom edge are dropped
        if (xn < COLS && yn < ROWS) begin
          idx = yn * COLS + xn;
          for (int c = 0; c < 3; c++) begin
            prod = 16'(rgb[c]) * 16'(wts[k]);
            shadow_frame[idx][c] = add_clamped(shadow_frame[idx][c], prod[15:8]);
          end
        end
      end
    endfunction

    function void check_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", '0, {r, g, b});
        return;
      end
      want = pending_pixels.pop_front();
      if (want.red !== r)   note_mismatch("pix_red", PIX_W'(want.red), PIX_W'(r));
      if (want.green !== g) note_mismatch("pix_green", PIX_W'(want.green), PIX_W'(g));
      if (want.blue !== b)  note_mismatch("pix_blue", PIX_W'(want.blue), PIX_W'(b));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             op_i;
  logic [POS_W-1:0] x_pos_i;
  logic [POS_W-1:0] y_pos_i;
  logic [CH_W-1:0]  red_in_i;
  logic [CH_W-1:0]  green_in_i;
  logic [CH_W-1:0]  blue_in_i;
  logic [CRD_W-1:0] read_col_i;
  logic [CRD_W-1:0] read_row_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [CH_W-1:0]  pix_red_o;
  logic [CH_W-1:0]  pix_green_o;
  logic [CH_W-1:0]  pix_blue_o;

  splat_tracker tracker;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles;

  subpixel_splat_framebuffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .read_col_i  (read_col_i),
    .read_row_i  (read_row_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_red_o   (pix_red_o),
    .pix_green_o (pix_green_o),
    .pix_blue_o  (pix_blue_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_pixel(pix_red_o, pix_green_o, pix_blue_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(op_e op, logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                              logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b, logic [CRD_W-1:0] rc,
                              logic [CRD_W-1:0] rr);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    x_pos_i    <= xp;
    y_pos_i    <= yp;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    read_col_i <= rc;
    read_row_i <= rr;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(op, xp, yp, r, g, b, rc, rr);
  endtask

  task automatic plot_at(logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                         logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    send_request(OP_PLOT, xp, yp, r, g, b, CRD_W'($urandom), CRD_W'($urandom));
  endtask

  task automatic read_at(logic [CRD_W-1:0] rc, logic [CRD_W-1:0] rr);
    send_request(OP_READ, POS_W'($urandom), POS_W'($urandom), CH_W'($urandom),
                 CH_W'($urandom), CH_W'($urandom), rc, rr);
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    // mostly faint colors so the store does not pin at full scale
    if ($urandom_range(0, 99) < 65) return CH_W'($urandom_range(0, 40));
    return CH_W'($urandom);
  endfunction

  initial begin
    int idle_plan  [4];
    int stall_plan [4];
    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    idle_plan      = '{0, 74, 0, 25};
    stall_plan     = '{0, 0, 74, 25};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OP_PLOT;
    x_pos_i        = '0;
    y_pos_i        = '0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    read_col_i     = '0;
    read_row_i     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    read_at(4'd0, 4'd0);
    read_at(4'd15, 4'd15);
    plot_at(12'h000, 12'h000, 8'hFF, 8'hFF, 8'hFF);
    read_at(4'd0, 4'd0);
    read_at(4'd1, 4'd0);
    plot_at(12'h0FF, 12'h0FF, 8'h80, 8'h40, 8'h01);
    read_at(4'd1, 4'd1);
    read_at(4'd0, 4'd1);
    plot_at(12'hFFF, 12'hFFF, 8'd200, 8'd100, 8'd50);
    read_at(4'd15, 4'd15);
    plot_at(12'hF80, 12'h340, 8'hFF, 8'h00, 8'hFF);
    read_at(4'd15, 4'd3);
    plot_at(12'h280, 12'hF80, 8'h7F, 8'hFF, 8'h00);
    read_at(4'd2, 4'd15);
    plot_at(12'h000, 12'h000, 8'hFF, 8'hFF, 8'hFF);
    read_at(4'd0, 4'd0);
    plot_at(12'h580, 12'h580, 8'h00, 8'h00, 8'h00);
    read_at(4'd5, 4'd5);
    read_at(4'd0, 4'd15);
    read_at(4'd15, 4'd0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if ($urandom_range(0, 99) < 40)
          read_at(CRD_W'($urandom), CRD_W'($urandom));
        else
          plot_at(POS_W'($urandom), POS_W'($urandom), pick_channel(), pick_channel(),
                  pick_channel());
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending_pixels.size() != 0)
      tracker.note_mismatch("missing pixels", PIX_W'(tracker.pending_pixels.size()), '0);
    if (tracker.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ssf_pkg.sv
rtl/core/ssf_ram.sv
rtl/core/ssf_ctrl.sv
rtl/core/ssf_dp.sv
rtl/core/subpixel_splat_framebuffer.sv
bench/tb_top.sv
